// ===== rtl/neighbor_sequence_gap_tracker_assert.svh =====
// assertion macros for the gap tracker
`ifndef NEIGHBOR_SEQUENCE_GAP_TRACKER_ASSERT_SVH
`define NEIGHBOR_SEQUENCE_GAP_TRACKER_ASSERT_SVH

// condition implies expression in the same cycle
`define NSGT_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("gap tracker check failed");

// condition implies expression in the next cycle
`define NSGT_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("gap tracker check failed");

`endif

// ===== rtl/nsgt_pkg.sv =====
`timescale 1ns / 1ps
package nsgt_pkg;

   localparam int SEQ_W            = 8;
   localparam int NEIGHBORS_DEF    = 16;
   localparam int MISSED_SLOTS_DEF = 8;
   localparam logic [7:0] WAIT_LIMIT_RST = 8'd3;
   localparam logic [7:0] WAIT_MAX       = 8'hFF;

   typedef enum logic [1:0] {
      MODE_PACKET = 2'd0,
      MODE_PRESET = 2'd1,
      MODE_BEACON = 2'd2,
      MODE_TICK   = 2'd3
   } mode_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic start;
      logic load_step;
      logic decide;
      logic gap_step;
      logic catch_step;
      logic store_step;
      logic result_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic load_done;
      logic out_of_range;
      logic go_gap;
      logic go_catch;
      logic gap_last;
      logic catch_done;
      logic store_done;
      logic rsp_free;
   } stat_type;

endpackage

// ===== rtl/neighbor_sequence_gap_tracker.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake           | beat
// req     | in        | req_valid/req_stall | mode, neighbor, seq_number
// rsp     | out       | rsp_valid/rsp_stall | accepted, numbers, flags
// csr     | in        | csr_valid/csr_ready | wait_limit
//
// one item at a time: a load pass, a decision, then a gap loop over each
// skipped number (up to 126) or a catch-up loop on a retransmission or
// give-up, a store pass and the result; the loops run on the single tracker copy
// loaded from the record and slot memories
// after reset a clearing pass sweeps the record memory
// the result register holds a stalled beat while the next item is taken
module neighbor_sequence_gap_tracker import nsgt_pkg::*; #(
   parameter int NEIGHBORS    = NEIGHBORS_DEF,
   parameter int MISSED_SLOTS = MISSED_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_mode,
   input  logic [3:0]       req_neighbor,
   input  logic [SEQ_W-1:0] req_seq_number,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_accepted,
   output logic [SEQ_W-1:0] rsp_current_out,
   output logic [SEQ_W-1:0] rsp_last_heard_out,
   output logic             rsp_synchronizing,
   output logic             rsp_list_overflow,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);

`include "neighbor_sequence_gap_tracker_assert.svh"

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   nsgt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   nsgt_datapath #(
      .NEIGHBORS    (NEIGHBORS),
      .MISSED_SLOTS (MISSED_SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_mode           (req_mode),
      .req_neighbor       (req_neighbor),
      .req_seq_number     (req_seq_number),
      .csr_valid          (csr_valid && csr_ready),
      .csr_data           (csr_data),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_accepted       (rsp_accepted),
      .rsp_current_out    (rsp_current_out),
      .rsp_last_heard_out (rsp_last_heard_out),
      .rsp_synchronizing  (rsp_synchronizing),
      .rsp_list_overflow  (rsp_list_overflow)
   );

   // checks
   `NSGT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `NSGT_ASSERT_NOW(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))
   `NSGT_ASSERT_NOW(a_overflow_resyncs, clock, reset, rsp_valid && rsp_list_overflow, rsp_synchronizing)

endmodule

// ===== rtl/nsgt_ctrl.sv =====
`timescale 1ns / 1ps
module nsgt_ctrl import nsgt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_LOAD   = 9'b000000100,
      ST_DECIDE = 9'b000001000,
      ST_GAP    = 9'b000010000,
      ST_CATCH  = 9'b000100000,
      ST_STORE  = 9'b001000000,
      ST_RESULT = 9'b010000000,
      ST_SPARE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_step = 1'b1;
            if (stat.load_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (stat.out_of_range) state_in = ST_RESULT;
            else if (stat.go_gap) state_in = ST_GAP;
            else if (stat.go_catch) state_in = ST_CATCH;
            else state_in = ST_STORE;
         end
         ST_GAP: begin
            cmd.gap_step = 1'b1;
            if (stat.gap_last) state_in = ST_STORE;
         end
         ST_CATCH: begin
            cmd.catch_step = 1'b1;
            if (stat.catch_done) state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.store_step = 1'b1;
            if (stat.store_done) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (stat.rsp_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_SPARE: state_in = ST_CLEAR;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== rtl/nsgt_datapath.sv =====
`timescale 1ns / 1ps
module nsgt_datapath import nsgt_pkg::*; #(
   parameter int NEIGHBORS    = NEIGHBORS_DEF,
   parameter int MISSED_SLOTS = MISSED_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       req_mode,
   input  logic [3:0]       req_neighbor,
   input  logic [SEQ_W-1:0] req_seq_number,
   input  logic             csr_valid,
   input  logic [7:0]       csr_data,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic             rsp_accepted,
   output logic [SEQ_W-1:0] rsp_current_out,
   output logic [SEQ_W-1:0] rsp_last_heard_out,
   output logic             rsp_synchronizing,
   output logic             rsp_list_overflow
);

   localparam int NIDX_W = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
   localparam int SIDX_W = (MISSED_SLOTS > 1) ? $clog2(MISSED_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MISSED_SLOTS + 1);
   localparam int NUM_AW = NIDX_W + SIDX_W;
   localparam int REC_W  = 3 * SEQ_W + 1 + MISSED_SLOTS;

   // tracker memories
   logic [REC_W-1:0] st_mem [NEIGHBORS];
   logic [SEQ_W-1:0] num_mem [1 << NUM_AW];
   logic [REC_W-1:0] st_rdata_ff;
   logic [SEQ_W-1:0] num_rdata_ff;

   // item and working copy of one tracker
   mode_type              mode_ff, mode_in;
   logic [NIDX_W-1:0]     nidx_ff, nidx_in;
   logic                  oor_ff, oor_in;
   logic [SEQ_W-1:0]      seq_ff, seq_in;
   logic [SEQ_W-1:0]      cur_ff, cur_in;
   logic [SEQ_W-1:0]      last_ff, last_in;
   logic                  work_ff, work_in;
   logic [7:0]            wait_ff, wait_in;
   logic [MISSED_SLOTS-1:0] mask_ff, mask_in;
   logic [SEQ_W-1:0]      slot_ff [MISSED_SLOTS];
   logic                  acc_ff, acc_in;
   logic                  ovf_ff, ovf_in;
   logic [SEQ_W-1:0]      nxt_ff, nxt_in;
   logic [6:0]            rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [NIDX_W-1:0]     clr_ff;
   logic [7:0]            limit_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_acc_ff, rsp_sync_ff, rsp_ovf_ff;
   logic [SEQ_W-1:0]      rsp_cur_ff, rsp_last_ff;

   // derived values
   logic [31:0]       nb_ext;
   logic [NIDX_W-1:0] req_nidx;
   logic [CNT_W-1:0]  cnt_m1;
   logic [SIDX_W-1:0] ld_idx, st_idx;
   logic [SEQ_W-1:0]  tgt, seq_gap, gap_cnt;
   logic              newer;
   logic              free_hit, match_any;
   logic [SIDX_W-1:0] free_idx, match_idx;

   assign nb_ext   = 32'(req_neighbor);
   assign req_nidx = nb_ext[NIDX_W-1:0];
   assign cnt_m1   = cnt_ff - CNT_W'(1);
   assign ld_idx   = cnt_m1[SIDX_W-1:0];
   assign st_idx   = cnt_ff[SIDX_W-1:0];
   assign tgt      = last_ff + SEQ_W'(1);
   assign seq_gap  = seq_ff - cur_ff;
   assign gap_cnt  = seq_gap - SEQ_W'(1);
   assign newer    = (seq_gap != '0) && !seq_gap[SEQ_W-1];

   // lowest free slot
   always_comb begin
      free_hit = 1'b0;
      free_idx = '0;
      for (int k = MISSED_SLOTS - 1; k >= 0; k--) begin
         if (!mask_ff[k]) begin
            free_hit = 1'b1;
            free_idx = SIDX_W'(k);
         end
      end
   end

   // lowest slot holding last heard plus one
   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      for (int k = MISSED_SLOTS - 1; k >= 0; k--) begin
         if (mask_ff[k] && (slot_ff[k] == tgt)) begin
            match_any = 1'b1;
            match_idx = SIDX_W'(k);
         end
      end
   end

   // status
   always_comb begin
      stat.clear_done   = (clr_ff == NIDX_W'(NEIGHBORS - 1));
      stat.load_done    = (cnt_ff == CNT_W'(MISSED_SLOTS));
      stat.store_done   = (cnt_ff == CNT_W'(MISSED_SLOTS - 1));
      stat.out_of_range = oor_ff;
      stat.go_gap       = (mode_ff == MODE_PACKET) && work_ff && newer
                          && (gap_cnt != '0);
      stat.go_catch     = work_ff
                          && (((mode_ff == MODE_PACKET) && !newer && (seq_ff == tgt))
                          || ((mode_ff == MODE_BEACON) && (wait_ff > limit_ff)));
      stat.gap_last     = (rem_ff == 7'd1);
      stat.catch_done   = (cur_ff == last_ff) || match_any;
      stat.rsp_free     = !rsp_valid_ff || !rsp_stall;
   end

   // tracker update
   always_comb begin
      mode_in = mode_ff;
      nidx_in = nidx_ff;
      oor_in  = oor_ff;
      seq_in  = seq_ff;
      cur_in  = cur_ff;
      last_in = last_ff;
      work_in = work_ff;
      wait_in = wait_ff;
      mask_in = mask_ff;
      acc_in  = acc_ff;
      ovf_in  = ovf_ff;
      nxt_in  = nxt_ff;
      rem_in  = rem_ff;
      cnt_in  = (cmd.load_step || cmd.store_step) ? cnt_ff + CNT_W'(1) : '0;

      if (cmd.start) begin
         mode_in = mode_type'(req_mode);
         nidx_in = req_nidx;
         oor_in  = (nb_ext >= 32'(NEIGHBORS));
         seq_in  = req_seq_number;
         acc_in  = 1'b1;
         ovf_in  = 1'b0;
      end

      if (cmd.load_step && (cnt_ff == '0)) begin
         {cur_in, last_in, work_in, wait_in, mask_in} = st_rdata_ff;
      end

      if (cmd.decide && !oor_ff) begin
         case (mode_ff)
            MODE_PACKET: begin
               if (work_ff) begin
                  if (newer) begin
                     if (gap_cnt == '0) begin
                        cur_in = seq_ff;
                        if (mask_ff == '0) last_in = seq_ff;
                     end else begin
                        nxt_in = cur_ff + SEQ_W'(1);
                        rem_in = gap_cnt[6:0];
                     end
                  end else if (seq_ff == tgt) begin
                     wait_in = '0;
                     last_in = tgt;
                     if (match_any) mask_in[match_idx] = 1'b0;
                  end else begin
                     acc_in = 1'b0;
                  end
               end
            end
            MODE_PRESET: begin
               cur_in  = seq_ff;
               last_in = seq_ff;
            end
            MODE_BEACON: begin
               if (work_ff) begin
                  if (wait_ff > limit_ff) begin
                     wait_in = '0;
                     last_in = tgt;
                     if (match_any) mask_in[match_idx] = 1'b0;
                  end
               end else begin
                  cur_in  = seq_ff;
                  last_in = seq_ff;
                  work_in = 1'b1;
               end
            end
            default: begin
               if (wait_ff != WAIT_MAX) wait_in = wait_ff + 8'd1;
            end
         endcase
      end

      // one skipped number per cycle
      if (cmd.gap_step) begin
         if (free_hit) begin
            mask_in[free_idx] = 1'b1;
         end else begin
            ovf_in  = 1'b1;
            work_in = 1'b0;
            wait_in = '0;
            mask_in = '0;
         end
         nxt_in = nxt_ff + SEQ_W'(1);
         rem_in = rem_ff - 7'd1;
         if (rem_ff == 7'd1) begin
            cur_in = seq_ff;
            if (mask_in == '0) last_in = seq_ff;
         end
      end

      // catch-up, one number per cycle
      if (cmd.catch_step && !((cur_ff == last_ff) || match_any)) last_in = tgt;
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      nidx_ff <= nidx_in;
      oor_ff  <= oor_in;
      seq_ff  <= seq_in;
      cur_ff  <= cur_in;
      last_ff <= last_in;
      work_ff <= work_in;
      wait_ff <= wait_in;
      mask_ff <= mask_in;
      acc_ff  <= acc_in;
      ovf_ff  <= ovf_in;
      nxt_ff  <= nxt_in;
      rem_ff  <= rem_in;
   end

   // slot copies
   always_ff @(posedge clock) begin
      if (cmd.load_step && (cnt_ff != '0)) slot_ff[ld_idx] <= num_rdata_ff;
      if (cmd.gap_step && free_hit) slot_ff[free_idx] <= nxt_ff;
   end

   // counters and register
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         clr_ff   <= '0;
         limit_ff <= WAIT_LIMIT_RST;
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.clear_step) clr_ff <= clr_ff + NIDX_W'(1);
         if (csr_valid) limit_ff <= csr_data;
      end
   end

   // record memory
   always_ff @(posedge clock) begin
      if (cmd.clear_step) st_mem[clr_ff] <= '0;
      else if (cmd.store_step && (cnt_ff == '0))
         st_mem[nidx_ff] <= {cur_ff, last_ff, work_ff, wait_ff, mask_ff};
      if (cmd.start) st_rdata_ff <= st_mem[req_nidx];
   end

   // missed number memory
   always_ff @(posedge clock) begin
      if (cmd.store_step) num_mem[{nidx_ff, st_idx}] <= slot_ff[st_idx];
      num_rdata_ff <= num_mem[{nidx_ff, st_idx}];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_acc_ff  <= !oor_ff && acc_ff;
         rsp_cur_ff  <= oor_ff ? '0 : cur_ff;
         rsp_last_ff <= oor_ff ? '0 : last_ff;
         rsp_sync_ff <= !oor_ff && !work_ff;
         rsp_ovf_ff  <= !oor_ff && ovf_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_acc_ff;
   assign rsp_current_out    = rsp_cur_ff;
   assign rsp_last_heard_out = rsp_last_ff;
   assign rsp_synchronizing  = rsp_sync_ff;
   assign rsp_list_overflow  = rsp_ovf_ff;

endmodule

// ===== dv/neighbor_sequence_gap_tracker_test.sv =====
`timescale 1ns / 1ps
module neighbor_sequence_gap_tracker_test;
   import nsgt_pkg::*;

   localparam int NB    = 16;
   localparam int SLOTS = 8;
   // worst item: the per-item passes, a full gap and a full catch-up, plus a margin
   localparam int DRAIN = 2 * SLOTS + 4 + 126 + 255 + 50;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic       accepted;
      logic [7:0] current_num;
      logic [7:0] heard_num;
      logic       sync_flag;
      logic       overflow;
   } tracker_result_type;

   // per-neighbour tracker copy and queue of predicted result beats
   class gap_scoreboard;
      logic [7:0] cur_num [NB];
      logic [7:0] heard_num [NB];
      logic [7:0] wait_cnt [NB];
      logic       working [NB];
      logic       slot_used [NB][SLOTS];
      logic [7:0] slot_num [NB][SLOTS];
      logic [7:0] wait_limit;
      tracker_result_type pending_q[$];
      int         errors;

      function new();
         wait_limit = WAIT_LIMIT_RST;
         errors = 0;
         for (int n = 0; n < NB; n++) begin
            cur_num[n] = '0;
            heard_num[n] = '0;
            wait_cnt[n] = '0;
            working[n] = 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
               slot_used[n][s] = 1'b0;
               slot_num[n][s] = '0;
            end
         end
      endfunction

      function int find_missed(int n, logic [7:0] num);
         for (int s = 0; s < SLOTS; s++)
            if (slot_used[n][s] && slot_num[n][s] == num) return s;
         return SLOTS;
      endfunction

      function bit list_clear(int n);
         for (int s = 0; s < SLOTS; s++)
            if (slot_used[n][s]) return 1'b0;
         return 1'b1;
      endfunction

      function void drop_to_sync(int n);
         working[n] = 1'b0;
         wait_cnt[n] = '0;
         for (int s = 0; s < SLOTS; s++) begin
            slot_used[n][s] = 1'b0;
            slot_num[n][s] = '0;
         end
      endfunction

      // true when no slot was free
      function bit record_missed(int n, logic [7:0] num);
         for (int s = 0; s < SLOTS; s++)
            if (!slot_used[n][s]) begin
               slot_used[n][s] = 1'b1;
               slot_num[n][s] = num;
               return 1'b0;
            end
         drop_to_sync(n);
         return 1'b1;
      endfunction

      function void fill_gap(int n, logic [7:0] num);
         int s;
         wait_cnt[n] = '0;
         heard_num[n] = heard_num[n] + 8'd1;
         s = find_missed(n, num);
         if (s < SLOTS) begin
            slot_used[n][s] = 1'b0;
            slot_num[n][s] = '0;
         end
         while (cur_num[n] != heard_num[n]) begin
            if (find_missed(n, heard_num[n] + 8'd1) < SLOTS) break;
            heard_num[n] = heard_num[n] + 8'd1;
         end
      endfunction

      function void note_request(mode_type m, int n, logic [7:0] seq);
         tracker_result_type r;
         logic [7:0] seq_gap, base, count;
         r.accepted = 1'b1;
         r.overflow = 1'b0;
         case (m)
            MODE_PACKET: begin
               if (working[n]) begin
                  seq_gap = seq - cur_num[n];
                  if (seq_gap >= 8'd1 && seq_gap <= 8'd127) begin
                     base = cur_num[n] + 8'd1;
                     count = seq - base;
                     for (int i = 0; i < count; i++)
                        if (record_missed(n, base + i[7:0])) r.overflow = 1'b1;
                     cur_num[n] = seq;
                     if (list_clear(n)) heard_num[n] = seq;
                  end else if (seq == heard_num[n] + 8'd1) begin
                     fill_gap(n, seq);
                  end else begin
                     r.accepted = 1'b0;
                  end
               end
            end
            MODE_PRESET: begin
               cur_num[n] = seq;
               heard_num[n] = seq;
            end
            MODE_BEACON: begin
               if (working[n]) begin
                  if (wait_cnt[n] > wait_limit) fill_gap(n, heard_num[n] + 8'd1);
               end else begin
                  heard_num[n] = seq;
                  cur_num[n] = seq;
                  working[n] = 1'b1;
               end
            end
            default: begin
               if (wait_cnt[n] < WAIT_MAX) wait_cnt[n] = wait_cnt[n] + 8'd1;
            end
         endcase
         r.current_num = cur_num[n];
         r.heard_num = heard_num[n];
         r.sync_flag = !working[n];
         pending_q.push_back(r);
      endfunction

      function void check_result(tracker_result_type got);
         tracker_result_type exp;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            errors++;
            return;
         end
         exp = pending_q.pop_front();
         if (got.accepted !== exp.accepted) begin
            $display("%0t: accepted expected %h actual %h", $time, exp.accepted, got.accepted);
            errors++;
         end
         if (got.current_num !== exp.current_num) begin
            $display("%0t: current_out expected %h actual %h", $time, exp.current_num,
                     got.current_num);
            errors++;
         end
         if (got.heard_num !== exp.heard_num) begin
            $display("%0t: last_heard_out expected %h actual %h", $time, exp.heard_num,
                     got.heard_num);
            errors++;
         end
         if (got.sync_flag !== exp.sync_flag) begin
            $display("%0t: synchronizing expected %h actual %h", $time, exp.sync_flag,
                     got.sync_flag);
            errors++;
         end
         if (got.overflow !== exp.overflow) begin
            $display("%0t: list_overflow expected %h actual %h", $time, exp.overflow,
                     got.overflow);
            errors++;
         end
      endfunction
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   logic [1:0]       req_mode = MODE_PACKET;
   logic [3:0]       req_neighbor = 0;
   logic [SEQ_W-1:0] req_seq_number = 0;
   logic             rsp_valid;
   logic             rsp_stall = 0;
   logic             rsp_accepted;
   logic [SEQ_W-1:0] rsp_current_out;
   logic [SEQ_W-1:0] rsp_last_heard_out;
   logic             rsp_synchronizing;
   logic             rsp_list_overflow;
   logic             csr_valid = 0;
   logic             csr_ready;
   logic [7:0]       csr_data = 0;

   gap_scoreboard sb = new();
   int     idle_pct = 0;
   int     stall_pct = 0;
   longint cycles = 0;

   neighbor_sequence_gap_tracker dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_neighbor(req_neighbor), .req_seq_number(req_seq_number),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_accepted(rsp_accepted),
      .rsp_current_out(rsp_current_out), .rsp_last_heard_out(rsp_last_heard_out),
      .rsp_synchronizing(rsp_synchronizing), .rsp_list_overflow(rsp_list_overflow),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("neighbor_sequence_gap_tracker_test failed");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // result beat monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_accepted, rsp_current_out, rsp_last_heard_out,
                          rsp_synchronizing, rsp_list_overflow});
   end

   // one request beat, called at a falling edge, returns at a falling edge
   task automatic send_item(mode_type m, int n, logic [7:0] seq);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_mode <= m;
      req_neighbor <= n[3:0];
      req_seq_number <= seq;
      do @(posedge clock); while (req_stall);
      sb.note_request(m, n, seq);
      @(negedge clock);
   endtask

   // wait for every result and for any trailing work to finish
   task automatic wait_quiet();
      req_valid <= 0;
      @(negedge clock);
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic write_wait_limit(logic [7:0] value);
      csr_valid <= 1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.wait_limit = value;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // mostly well-formed traffic on a few neighbours, built on the tracked state
   task automatic random_item();
      int n, r;
      logic [7:0] seq;
      mode_type m;
      n = ($urandom_range(9) < 8) ? $urandom_range(3) : $urandom_range(NB - 1);
      r = $urandom_range(99);
      seq = 8'($urandom_range(255));
      if (r < 55) begin
         m = MODE_PACKET;
         r = $urandom_range(99);
         if (r < 50) seq = sb.cur_num[n] + 8'($urandom_range(1, 10));
         else if (r < 75) seq = sb.heard_num[n] + 8'd1;
         else if (r < 85) seq = sb.cur_num[n] + 8'($urandom_range(1, 127));
      end else if (r < 59) begin
         m = MODE_PRESET;
      end else if (r < 75) begin
         m = MODE_BEACON;
      end else begin
         m = MODE_TICK;
      end
      send_item(m, n, seq);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      write_wait_limit(8'd3);

      // directed: sync, gaps, overflow, retransmission, give-up, wrap, preset
      send_item(MODE_PACKET, 0, 8'd5);       // packet while synchronizing
      send_item(MODE_BEACON, 0, 8'd10);      // beacon synchronizes
      send_item(MODE_PACKET, 0, 8'd11);      // in order
      send_item(MODE_PACKET, 0, 8'd14);      // two missed
      send_item(MODE_PACKET, 0, 8'd12);      // retransmission
      send_item(MODE_PACKET, 0, 8'd12);      // duplicate rejected
      send_item(MODE_PACKET, 0, 8'd0);       // stale rejected
      send_item(MODE_PACKET, 0, 8'd13);      // closes gap, catch-up
      send_item(MODE_PACKET, 0, 8'd20);
      for (int i = 0; i < 5; i++) send_item(MODE_TICK, 0, 8'hFF);
      send_item(MODE_BEACON, 0, 8'd0);       // gives up on oldest missing
      send_item(MODE_PACKET, 0, 8'd141);     // gap of 120: overflow
      send_item(MODE_BEACON, 15, 8'd250);
      send_item(MODE_PACKET, 15, 8'd3);      // wrap past 255
      send_item(MODE_PACKET, 15, 8'd251);    // retransmission across wrap
      send_item(MODE_PRESET, 15, 8'hFF);
      send_item(MODE_PACKET, 15, 8'd127);    // distance 128 rejected
      send_item(MODE_PACKET, 15, 8'd126);    // distance 127, overflow
      send_item(MODE_PRESET, 7, 8'd0);
      send_item(MODE_BEACON, 7, 8'd170);
      send_item(MODE_PACKET, 7, 8'd85);
      wait_quiet();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  write_wait_limit(8'd0);   end
            1: begin idle_pct = 76; stall_pct = 0;  write_wait_limit(8'd255); end
            2: begin
               idle_pct = 0;  stall_pct = 76;
               write_wait_limit(8'($urandom_range(1, 254)));
            end
            default: begin idle_pct = 14; stall_pct = 14; write_wait_limit(8'd3); end
         endcase
         for (int i = 0; i < 300; i++) random_item();
         wait_quiet();
      end

      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("neighbor_sequence_gap_tracker_test passed");
      else
         $display("neighbor_sequence_gap_tracker_test failed");
      $finish;
   end

endmodule
